// ===== src/tlc_pkg.sv =====
// Shared types, result codes and cycle costs for the two-level LRU cache model.
package tlc_pkg;

	localparam int ADDR_W  = 32;
	localparam int OUTC_W  = 2;
	localparam int COST_W  = 12;
	localparam int TOTAL_W = 48;

	localparam logic [OUTC_W-1:0] OUTC_L1_HIT = 2'd0;
	localparam logic [OUTC_W-1:0] OUTC_L2_HIT = 2'd1;
	localparam logic [OUTC_W-1:0] OUTC_MISS   = 2'd2;

	localparam logic [COST_W-1:0] COST_L1_HIT = 12'd3;
	localparam logic [COST_W-1:0] COST_L2_HIT = 12'd55;
	localparam logic [COST_W-1:0] COST_MISS   = 12'd3639;

	typedef struct packed {
		logic load;
		logic idx_start;
		logic l1_rd;
		logic l1_upd;
		logic l2_rd;
		logic l2_upd;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic idx_ready;
		logic l1_hit;
	} stat_t;

	function automatic logic [COST_W-1:0] cost_of(input logic [OUTC_W-1:0] oc);
		logic [COST_W-1:0] c;
		case (oc)
			OUTC_L1_HIT: c = COST_L1_HIT;
			OUTC_L2_HIT: c = COST_L2_HIT;
			default:     c = COST_MISS;
		endcase
		return c;
	endfunction

endpackage

// ===== src/tlc_setidx.sv =====
// Set index unit: block number modulo the set count, masked or by reciprocal multiplication.
module tlc_setidx #(
	parameter int SETS = 4,
	parameter int W    = 25,
	parameter int IW   = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [W-1:0]  val,
	output logic [IW-1:0] idx,
	output logic          ready
);

	localparam bit POW2 = (SETS & (SETS - 1)) == 0;

	generate
		if (POW2) begin : g_mask
			logic [IW-1:0] idx_q;
			logic          rdy_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					rdy_q <= 1'b0;
				end else if (start) begin
					rdy_q <= 1'b1;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					idx_q <= IW'(val & W'(SETS - 1));
				end
			end

			assign idx   = idx_q;
			assign ready = rdy_q;
		end else begin : g_recip
			localparam int LW = $clog2(SETS);
			localparam int SH = W + LW;
			localparam int PW = 2 * W + 1;
			localparam longint unsigned MUL =
				((64'd1 << SH) + 64'(SETS) - 64'd1) / 64'(SETS);
			logic [W-1:0]  val_q;
			logic [W-1:0]  quo_q;
			logic [IW-1:0] r_q;
			logic [1:0]    step_q;
			logic          rdy_q;
			logic [PW-1:0] prod;
			logic [W-1:0]  rem;

			assign prod = PW'(val_q) * PW'(MUL);
			assign rem  = val_q - (quo_q * W'(SETS));

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					step_q <= '0;
					rdy_q  <= 1'b0;
				end else if (start) begin
					step_q <= 2'b01;
					rdy_q  <= 1'b0;
				end else begin
					step_q <= {step_q[0], 1'b0};
					if (step_q[1]) begin
						rdy_q <= 1'b1;
					end
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					val_q <= val;
				end
				if (step_q[0]) begin
					quo_q <= W'(prod >> SH);
				end
				if (step_q[1]) begin
					r_q <= rem[IW-1:0];
				end
			end

			assign idx   = r_q;
			assign ready = rdy_q;
		end
	endgenerate

endmodule

// ===== src/tlc_level.sv =====
// One cache level: per-set tag, valid and age rows with true LRU update.
module tlc_level #(
	parameter int SETS = 4,
	parameter int WAYS = 8,
	parameter int OFF  = 7,
	parameter int IW   = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd,
	input  logic                           upd,
	input  logic [IW-1:0]                  idx,
	input  logic [tlc_pkg::ADDR_W-OFF-1:0] blk,
	output logic                           hit
);

	localparam int TW = tlc_pkg::ADDR_W - OFF;
	localparam int AW = $clog2(WAYS);

	logic [WAYS-1:0][TW-1:0] tag_mem [SETS];
	logic [WAYS-1:0]         vld_mem [SETS];
	logic [WAYS-1:0][AW-1:0] age_mem [SETS];
	logic [SETS-1:0]         row_ok_q;

	logic [WAYS-1:0][TW-1:0] tag_rd_q;
	logic [WAYS-1:0]         vld_rd_q;
	logic [WAYS-1:0][AW-1:0] age_rd_q;
	logic                    row_ok_rd_q;

	logic [WAYS-1:0]         vld;
	logic [WAYS-1:0]         hit_vec;
	logic                    full;
	logic [AW-1:0]           hit_way;
	logic [AW-1:0]           free_way;
	logic [AW-1:0]           vict_way;
	logic [AW-1:0]           sel_way;
	logic [AW-1:0]           old_age;
	logic [WAYS-1:0][TW-1:0] tag_new;
	logic [WAYS-1:0]         vld_new;
	logic [WAYS-1:0][AW-1:0] age_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ok_q <= '0;
		end else if (upd) begin
			row_ok_q[idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd) begin
			tag_rd_q    <= tag_mem[idx];
			vld_rd_q    <= vld_mem[idx];
			age_rd_q    <= age_mem[idx];
			row_ok_rd_q <= row_ok_q[idx];
		end
		if (upd) begin
			tag_mem[idx] <= tag_new;
			vld_mem[idx] <= vld_new;
			age_mem[idx] <= age_new;
		end
	end

	always_comb begin
		vld      = row_ok_rd_q ? vld_rd_q : '0;
		full     = &vld;
		hit_way  = '0;
		free_way = '0;
		vict_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			hit_vec[w] = vld[w] && (tag_rd_q[w] == blk);
			if (hit_vec[w]) begin
				hit_way = AW'(w);
			end
			if (!vld[w]) begin
				free_way = AW'(w);
			end
			if (vld[w] && (age_rd_q[w] == AW'(WAYS - 1))) begin
				vict_way = AW'(w);
			end
		end
		hit     = |hit_vec;
		sel_way = hit ? hit_way : (full ? vict_way : free_way);
		old_age = age_rd_q[hit_way];
		for (int w = 0; w < WAYS; w++) begin
			if (AW'(w) == sel_way) begin
				tag_new[w] = blk;
				vld_new[w] = 1'b1;
				age_new[w] = '0;
			end else begin
				tag_new[w] = tag_rd_q[w];
				vld_new[w] = vld[w];
				age_new[w] = (vld[w] && (!hit || (age_rd_q[w] < old_age)))
				             ? age_rd_q[w] + 1'b1 : age_rd_q[w];
			end
		end
	end

endmodule

// ===== src/tlc_datapath.sv =====
// Datapath: address word, set index units, both cache levels and cycle accounting.
module tlc_datapath #(
	parameter int L1_SETS        = 1,
	parameter int L2_SETS        = 4,
	parameter int WAYS           = 8,
	parameter int L1_OFFSET_BITS = 4,
	parameter int L2_OFFSET_BITS = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tlc_pkg::cmd_t                 cmd,
	output tlc_pkg::stat_t                stat,
	input  logic [tlc_pkg::ADDR_W-1:0]    address,
	output logic                          done,
	output logic [tlc_pkg::OUTC_W-1:0]    outcome,
	output logic [tlc_pkg::COST_W-1:0]    access_cost,
	output logic [tlc_pkg::TOTAL_W-1:0]   total_cycles
);

	localparam int AW    = tlc_pkg::ADDR_W;
	localparam int TOTW  = tlc_pkg::TOTAL_W;
	localparam int L1_TW = AW - L1_OFFSET_BITS;
	localparam int L2_TW = AW - L2_OFFSET_BITS;
	localparam int L1_IW = (L1_SETS > 1) ? $clog2(L1_SETS) : 1;
	localparam int L2_IW = (L2_SETS > 1) ? $clog2(L2_SETS) : 1;

	logic [AW-1:0]                 addr_q;
	logic [L1_IW-1:0]              idx1;
	logic [L2_IW-1:0]              idx2;
	logic                          rdy1;
	logic                          rdy2;
	logic                          hit1;
	logic                          hit2;
	logic [tlc_pkg::OUTC_W-1:0]    oc_q;
	logic [tlc_pkg::OUTC_W-1:0]    oc_out_q;
	logic [tlc_pkg::COST_W-1:0]    cost;
	logic [tlc_pkg::COST_W-1:0]    cost_q;
	logic [TOTW-1:0]               total_q;
	logic [TOTW:0]                 sum;
	logic                          done_q;

	tlc_setidx #(.SETS(L1_SETS), .W(L1_TW), .IW(L1_IW)) u_idx1 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.idx_start),
		.val    (address[AW-1:L1_OFFSET_BITS]),
		.idx    (idx1),
		.ready  (rdy1)
	);

	tlc_setidx #(.SETS(L2_SETS), .W(L2_TW), .IW(L2_IW)) u_idx2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.idx_start),
		.val    (address[AW-1:L2_OFFSET_BITS]),
		.idx    (idx2),
		.ready  (rdy2)
	);

	tlc_level #(.SETS(L1_SETS), .WAYS(WAYS), .OFF(L1_OFFSET_BITS), .IW(L1_IW)) u_l1 (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (cmd.l1_rd),
		.upd    (cmd.l1_upd),
		.idx    (idx1),
		.blk    (addr_q[AW-1:L1_OFFSET_BITS]),
		.hit    (hit1)
	);

	tlc_level #(.SETS(L2_SETS), .WAYS(WAYS), .OFF(L2_OFFSET_BITS), .IW(L2_IW)) u_l2 (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (cmd.l2_rd),
		.upd    (cmd.l2_upd),
		.idx    (idx2),
		.blk    (addr_q[AW-1:L2_OFFSET_BITS]),
		.hit    (hit2)
	);

	assign stat.idx_ready = rdy1 & rdy2;
	assign stat.l1_hit    = hit1;

	assign cost = tlc_pkg::cost_of(oc_q);
	assign sum  = {1'b0, total_q} + (TOTW + 1)'(cost);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q <= address;
		end
		if (cmd.l1_upd) begin
			oc_q <= hit1 ? tlc_pkg::OUTC_L1_HIT : tlc_pkg::OUTC_MISS;
		end
		if (cmd.l2_upd) begin
			oc_q <= hit2 ? tlc_pkg::OUTC_L2_HIT : tlc_pkg::OUTC_MISS;
		end
		if (cmd.finish) begin
			oc_out_q <= oc_q;
			cost_q   <= cost;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.finish) begin
				total_q <= sum[TOTW] ? {TOTW{1'b1}} : sum[TOTW-1:0];
			end
		end
	end

	assign done         = done_q;
	assign outcome      = oc_out_q;
	assign access_cost  = cost_q;
	assign total_cycles = total_q;

endmodule

// ===== src/tlc_ctrl.sv =====
// Controller: sequences index, L1 lookup, optional L2 lookup and result issue.
module tlc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  tlc_pkg::stat_t stat,
	output tlc_pkg::cmd_t  cmd,
	output logic           busy
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_IDX  = 5'b00010,
		ST_L1   = 5'b00100,
		ST_L2   = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load      = 1'b1;
					cmd.idx_start = 1'b1;
					state_nxt     = ST_IDX;
				end
			end
			ST_IDX: begin
				if (stat.idx_ready) begin
					cmd.l1_rd = 1'b1;
					state_nxt = ST_L1;
				end
			end
			ST_L1: begin
				cmd.l1_upd = 1'b1;
				if (stat.l1_hit) begin
					state_nxt = ST_FIN;
				end else begin
					cmd.l2_rd = 1'b1;
					state_nxt = ST_L2;
				end
			end
			ST_L2: begin
				cmd.l2_upd = 1'b1;
				state_nxt  = ST_FIN;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_nxt  = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== src/two_level_lru_cache_model.sv =====
// Top level of the two-level tag-only LRU cache model.
// Pulse start with a byte address while busy is low; one result word follows, shown for
// a single cycle with done high, and it cannot be held off, so capture it on that edge.
// With power-of-two set counts the next word can be accepted at the edge that takes the
// result of the last. An access reads the L1 row, compares and writes it back, on a miss
// reads, compares and writes back the L2 row, adds the cost to the total and then
// presents the result. A set count that is not a power of two forms the set index by
// reciprocal multiplication, a quotient step and then a remainder step, before the L1
// row is read. Both levels start empty after reset with no clearing pass; total_cycles
// sticks at all ones once it saturates.
module two_level_lru_cache_model #(
	parameter int L1_SETS        = 1,
	parameter int L2_SETS        = 4,
	parameter int WAYS           = 8,
	parameter int L1_OFFSET_BITS = 4,
	parameter int L2_OFFSET_BITS = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [tlc_pkg::ADDR_W-1:0]    address,
	output logic                          done,
	output logic [tlc_pkg::OUTC_W-1:0]    outcome,
	output logic [tlc_pkg::COST_W-1:0]    access_cost,
	output logic [tlc_pkg::TOTAL_W-1:0]   total_cycles
);

	tlc_pkg::cmd_t  cmd;
	tlc_pkg::stat_t stat;

	tlc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	tlc_datapath #(
		.L1_SETS        (L1_SETS),
		.L2_SETS        (L2_SETS),
		.WAYS           (WAYS),
		.L1_OFFSET_BITS (L1_OFFSET_BITS),
		.L2_OFFSET_BITS (L2_OFFSET_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.address      (address),
		.done         (done),
		.outcome      (outcome),
		.access_cost  (access_cost),
		.total_cycles (total_cycles)
	);

endmodule

// ===== src/tlc_checker.sv =====
// Port checker for the two-level LRU cache model and its bind.
module tlc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [tlc_pkg::OUTC_W-1:0]    outcome,
	input logic [tlc_pkg::COST_W-1:0]    access_cost,
	input logic [tlc_pkg::TOTAL_W-1:0]   total_cycles
);

	localparam int TW = tlc_pkg::TOTAL_W;
	localparam logic [TW-1:0] TMAX = {TW{1'b1}};

	a_cost_matches: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((outcome == tlc_pkg::OUTC_L1_HIT) && (access_cost == tlc_pkg::COST_L1_HIT))
		      || ((outcome == tlc_pkg::OUTC_L2_HIT) && (access_cost == tlc_pkg::COST_L2_HIT))
		      || ((outcome == tlc_pkg::OUTC_MISS) && (access_cost == tlc_pkg::COST_MISS)))
		else $error("outcome and access cost disagree");

	a_total_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> $stable(total_cycles))
		else $error("total changed without a result");

	a_total_adds: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(total_cycles) <= (TMAX - TW'(access_cost))))
		|-> (total_cycles == ($past(total_cycles) + TW'(access_cost))))
		else $error("total is not the running sum");

	a_total_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(total_cycles) > (TMAX - TW'(access_cost))))
		|-> (total_cycles == TMAX))
		else $error("total did not saturate");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

endmodule

bind two_level_lru_cache_model tlc_checker u_tlc_checker (.*);
